>>> rtl/dmwbc_pkg.sv
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared constants and controller/datapath command and status types for the
// direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

  localparam int DFLT_LINES      = 32;
  localparam int DFLT_LINE_BYTES = 8;
  localparam int DFLT_ADDR_BITS  = 16;
  localparam int BYTE_W          = 8;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic load_req;
    logic step_div;
    logic step_split;
    logic step_index;
    logic tag_read;
    logic check;
    logic cnt_clear;
    logic cnt_inc;
    logic clr_write;
    logic wb_read;
    logic wb_write;
    logic fill_read;
    logic fill_write;
    logic alloc;
    logic access_read;
    logic access_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_last;
    logic line_hit;
    logic victim;
    logic is_write;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/direct_mapped_writeback_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped, write-back, write-allocate byte cache with its own backing
// memory.
//
// Request channel (req_valid/req_stall): req_type (0 read, 1 write), address,
// write_data. Response channel (rsp_valid/rsp_stall): read_data, hit and
// was_dirty, one item per read, none per write.
// One request is worked on at a time. A hit passes through the address split,
// tag check and line access; a miss adds a byte-serial refill, and a dirty
// victim is first written back byte by byte, both paced by the single-port
// line store and backing memory.
// Reset clears all line valid and dirty flags, then sweeps the backing memory
// to zero, one byte a cycle, with req_stall high.
// The result sits in an output register; a request may be accepted while it
// waits. A read whose result is ready holds in its last step while rsp_stall
// keeps the previous result in place.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache #(
  parameter int LINES      = dmwbc_pkg::DFLT_LINES,
  parameter int LINE_BYTES = dmwbc_pkg::DFLT_LINE_BYTES,
  parameter int ADDR_BITS  = dmwbc_pkg::DFLT_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [ADDR_BITS-1:0]          address,
  input  logic [dmwbc_pkg::BYTE_W-1:0]  write_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [dmwbc_pkg::BYTE_W-1:0]  read_data,
  output logic                          hit,
  output logic                          was_dirty
);
  import dmwbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dmwbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dmwbc_dpath #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req_type),
    .address    (address),
    .write_data (write_data),
    .rsp_stall  (rsp_stall),
    .rsp_valid  (rsp_valid),
    .read_data  (read_data),
    .hit        (hit),
    .was_dirty  (was_dirty)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> cmd.step_div)
    else $error("accepted item did not start the address split");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while held");

  a_line_port: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wb_read, cmd.access_read, cmd.fill_write, cmd.access_write}))
    else $error("line store port used twice in one cycle");

  a_bmem_port: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_write, cmd.wb_write, cmd.fill_read}))
    else $error("backing memory port used twice in one cycle");

endmodule

>>> rtl/dmwbc_ctrl.sv
// ----------------------------------------------------------------------------
// dmwbc_ctrl
// Sequencer: clearing pass, address split, tag check, write-back, refill,
// the final line access and the hand-off to the result register.
// ----------------------------------------------------------------------------
module dmwbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output dmwbc_pkg::cmd_t   cmd,
  input  dmwbc_pkg::sts_t   sts
);
  import dmwbc_pkg::*;

  typedef enum logic [12:0] {
    ST_CLEAR   = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_DIV     = 13'b0000000000100,
    ST_SPLIT   = 13'b0000000001000,
    ST_INDEX   = 13'b0000000010000,
    ST_TAG     = 13'b0000000100000,
    ST_CHECK   = 13'b0000001000000,
    ST_WB_RD   = 13'b0000010000000,
    ST_WB_WR   = 13'b0000100000000,
    ST_FILL_RD = 13'b0001000000000,
    ST_FILL_WR = 13'b0010000000000,
    ST_ACCESS  = 13'b0100000000000,
    ST_RESP    = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step_div = 1'b1;
        state_next   = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.step_split = 1'b1;
        state_next     = ST_INDEX;
      end
      ST_INDEX: begin
        cmd.step_index = 1'b1;
        state_next     = ST_TAG;
      end
      ST_TAG: begin
        cmd.tag_read = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check     = 1'b1;
        cmd.cnt_clear = 1'b1;
        if (sts.line_hit) begin
          state_next = ST_ACCESS;
        end else if (sts.victim) begin
          state_next = ST_WB_RD;
        end else begin
          state_next = ST_FILL_RD;
        end
      end
      ST_WB_RD: begin
        cmd.wb_read = 1'b1;
        state_next  = ST_WB_WR;
      end
      ST_WB_WR: begin
        cmd.wb_write = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clear = 1'b1;
          state_next    = ST_FILL_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_WB_RD;
        end
      end
      ST_FILL_RD: begin
        cmd.fill_read = 1'b1;
        state_next    = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd.fill_write = 1'b1;
        if (sts.cnt_last) begin
          cmd.alloc  = 1'b1;
          state_next = ST_ACCESS;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_FILL_RD;
        end
      end
      ST_ACCESS: begin
        if (sts.is_write) begin
          cmd.access_write = 1'b1;
          state_next       = ST_IDLE;
        end else begin
          cmd.access_read = 1'b1;
          state_next      = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/dmwbc_dpath.sv
// ----------------------------------------------------------------------------
// dmwbc_dpath
// Datapath: address split by constant reciprocals, tag store, valid/dirty
// flags, line store, backing memory and the result register.
// ----------------------------------------------------------------------------
module dmwbc_dpath #(
  parameter int LINES      = dmwbc_pkg::DFLT_LINES,
  parameter int LINE_BYTES = dmwbc_pkg::DFLT_LINE_BYTES,
  parameter int ADDR_BITS  = dmwbc_pkg::DFLT_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dmwbc_pkg::cmd_t               cmd,
  output dmwbc_pkg::sts_t               sts,
  input  logic                          req_type,
  input  logic [ADDR_BITS-1:0]          address,
  input  logic [dmwbc_pkg::BYTE_W-1:0]  write_data,
  input  logic                          rsp_stall,
  output logic                          rsp_valid,
  output logic [dmwbc_pkg::BYTE_W-1:0]  read_data,
  output logic                          hit,
  output logic                          was_dirty
);
  import dmwbc_pkg::*;

  localparam int AW  = ADDR_BITS;
  localparam int OW  = $clog2(LINE_BYTES);
  localparam int IW  = $clog2(LINES);
  localparam int LW  = $clog2(LINES * LINE_BYTES);
  localparam int TW  = $clog2(((1 << AW) - 1) / LINE_BYTES + 1);
  localparam int SD  = AW + OW;
  localparam int SL  = TW + IW;
  localparam int P1W = SD + TW;
  localparam int P2W = SL + TW;
  localparam int QMW = TW + IW;
  localparam int BMW = TW + OW + 1;

  localparam logic [63:0] MD_FULL =
    ((64'd1 << SD) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES);
  localparam logic [63:0] ML_FULL =
    ((64'd1 << SL) + 64'(LINES) - 64'd1) / 64'(LINES);
  localparam logic [AW:0] MD = MD_FULL[AW:0];
  localparam logic [TW:0] ML = ML_FULL[TW:0];
  localparam logic [OW-1:0] OFF_LAST = OW'(LINE_BYTES - 1);

  // request
  logic              req_wr;
  logic [AW-1:0]     addr_r;
  logic [BYTE_W-1:0] wdata_r;

  // address split
  logic [TW-1:0]  lnum, qq, tag_q;
  logic [AW-1:0]  lbase, vbase;
  logic [OW-1:0]  off, cnt;
  logic [IW-1:0]  idx;
  logic [LW-1:0]  lb;
  logic [P1W-1:0] p1;
  logic [P2W-1:0] p2;
  logic [QMW-1:0] qm, lnum_x;
  logic [BMW-1:0] lb_mul, vb_mul;

  logic            hit_r, dirty_r;
  logic [AW-1:0]   clr_addr;
  logic [LINES-1:0] line_valid, line_dirty;

  // stores
  logic [TW-1:0]     tag_mem  [LINES];
  logic [BYTE_W-1:0] line_mem [LINES * LINE_BYTES];
  logic [BYTE_W-1:0] bmem     [2 ** AW];
  logic [BYTE_W-1:0] line_q, bmem_q;

  logic              b_we;
  logic [AW-1:0]     b_addr;
  logic [BYTE_W-1:0] b_wd;
  logic              l_we, l_re;
  logic [LW-1:0]     l_addr;
  logic [BYTE_W-1:0] l_wd;

  assign p1     = P1W'(addr_r) * P1W'(MD);
  assign p2     = P2W'(lnum) * P2W'(ML);
  assign qm     = QMW'(qq) * QMW'(LINES);
  assign lnum_x = QMW'(lnum);
  assign lb_mul = BMW'(lnum) * BMW'(LINE_BYTES);
  assign vb_mul = BMW'(tag_q) * BMW'(LINE_BYTES);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_wr  <= (req_type == REQ_WRITE);
      addr_r  <= address;
      wdata_r <= write_data;
    end
    if (cmd.step_div) lnum <= p1[SD +: TW];
    if (cmd.step_split) begin
      qq    <= p2[SL +: TW];
      lbase <= lb_mul[AW-1:0];
    end
    if (cmd.step_index) begin
      idx <= lnum_x[IW-1:0] - qm[IW-1:0];
      off <= addr_r[OW-1:0] - lbase[OW-1:0];
    end
    if (cmd.tag_read) begin
      tag_q <= tag_mem[idx];
      lb    <= LW'(idx) * LW'(LINE_BYTES);
    end
    if (cmd.check) begin
      hit_r   <= sts.line_hit;
      dirty_r <= line_dirty[idx];
      vbase   <= vb_mul[AW-1:0];
    end
    if (cmd.alloc) tag_mem[idx] <= lnum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      clr_addr   <= '0;
      line_valid <= '0;
      line_dirty <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.cnt_clear) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.clr_write) clr_addr <= clr_addr + 1'b1;
      if (cmd.alloc) begin
        line_valid[idx] <= 1'b1;
        line_dirty[idx] <= 1'b0;
      end
      if (cmd.access_write) line_dirty[idx] <= 1'b1;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // backing memory, single port
  always_comb begin
    b_we = cmd.clr_write | cmd.wb_write;
    b_wd = cmd.clr_write ? '0 : line_q;
    if (cmd.clr_write) begin
      b_addr = clr_addr;
    end else if (cmd.wb_write) begin
      b_addr = vbase + AW'(cnt);
    end else begin
      b_addr = lbase + AW'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_addr] <= b_wd;
    if (cmd.fill_read) bmem_q <= bmem[b_addr];
  end

  // line store, single port
  always_comb begin
    l_we   = cmd.fill_write | cmd.access_write;
    l_re   = cmd.wb_read | cmd.access_read;
    l_wd   = cmd.fill_write ? bmem_q : wdata_r;
    l_addr = (cmd.access_read | cmd.access_write) ? lb + LW'(off) : lb + LW'(cnt);
  end

  always_ff @(posedge clk) begin
    if (l_we) line_mem[l_addr] <= l_wd;
    if (l_re) line_q <= line_mem[l_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= line_q;
      hit       <= hit_r;
      was_dirty <= dirty_r;
    end
  end

  always_comb begin
    sts.clr_last = (clr_addr == '1);
    sts.cnt_last = (cnt == OFF_LAST);
    sts.line_hit = line_valid[idx] && (tag_q == lnum);
    sts.victim   = line_valid[idx] && line_dirty[idx];
    sts.is_write = req_wr;
    sts.out_free = !rsp_valid || !rsp_stall;
  end

endmodule
